// ===== hdl/lut2d_pkg.sv =====
// Package: payload types, action and status codes, state encoding for the 2-D LUT.
`default_nettype none
package lut2d_pkg;
  localparam int MaxRows = 16;
  localparam int MaxCols = 16;
  localparam int IdxW = 4;

  localparam logic [1:0] ACT_CELL  = 2'd0;
  localparam logic [1:0] ACT_XREF  = 2'd1;
  localparam logic [1:0] ACT_YREF  = 2'd2;
  localparam logic [1:0] ACT_QUERY = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_YOUT = 2'd1;
  localparam logic [1:0] ST_XOUT = 2'd2;

  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] data_value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] standardized_value;
    logic [1:0]         status;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_YRD, S_YCMP, S_RROW, S_LSET, S_MUL, S_DIV, S_LEND,
    S_XRD, S_XCMP, S_XSET, S_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== hdl/lut_2d_inverse_interpolation.sv =====
// Top level: 2-D look-up table with linear interpolation and a shared serial divider.
//
// Usage:
//   in_ channel: one word per action. Writes to the table or the reference
//   lists produce no result. A query produces exactly one out_ word:
//   the interpolated value with status ST_OK, or query_x unchanged
//   with status ST_YOUT / ST_XOUT when the y or x interval search fails.
//   cfg_ channel: index 0 sets columns_in_use, index 1 rows_in_use; others ignored.
//   in_stall is high while a query is being worked on or its result waits.
// Query steps:
//   A query walks the y list (a read and a compare per interval tried),
//   interpolates every used column (row read, set-up, one 32x32 multiply,
//   then a 64-bit restoring divider giving one quotient bit per cycle,
//   write-back), walks the interpolated row (a read and a compare per
//   interval) and does one more division.
// Reset:
//   rst_n (synchronous) clears control state and sets both counts to 16.
//   Storage holds garbage until written.
// Stall:
//   The result is held in out_word while out_stall is high; no new query
//   is taken until it has been delivered.
`default_nettype none
module lut_2d_inverse_interpolation (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  lut2d_pkg::in_word_t    in_word,
  output logic                   out_valid,
  input  wire                    out_stall,
  output lut2d_pkg::out_word_t   out_word,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  [0:0]             cfg_index,
  input  wire  [31:0]            cfg_data
);
  // storage
  logic signed [31:0] cell_mem [lut2d_pkg::MaxRows*lut2d_pkg::MaxCols];
  logic signed [31:0] xref_mem [lut2d_pkg::MaxCols];
  logic signed [31:0] yref_mem [lut2d_pkg::MaxRows];
  logic signed [31:0] irow_mem [lut2d_pkg::MaxCols];

  logic [4:0] cols_r, rows_r;
  lut2d_pkg::state_t state_r, state_nxt;
  logic [4:0] i_r, i_nxt;              // loop index
  logic [3:0] lo_r, lo_nxt;            // found interval
  logic signed [31:0] qx_r, qy_r;
  logic signed [31:0] a_r, b_r;        // read data, lower/upper
  logic signed [31:0] c0_r, c1_r;      // second read pair (cells / x refs)
  logic signed [31:0] x0_r, x1_r, y0_r;
  logic               neg_r;
  logic [63:0] num_r;                  // product, shifted out during division
  logic [32:0] den_r;
  logic [32:0] rem_r;
  logic [63:0] quo_r;
  logic [6:0]  cnt_r;
  logic        pass2_r;                // second (x) interpolation
  lut2d_pkg::out_word_t res_r;
  logic out_v_r;

  logic [4:0] cols_u, rows_u;
  assign cols_u = (cols_r > 5'(lut2d_pkg::MaxCols)) ? 5'(lut2d_pkg::MaxCols) : cols_r;
  assign rows_u = (rows_r > 5'(lut2d_pkg::MaxRows)) ? 5'(lut2d_pkg::MaxRows) : rows_r;

  logic accept;
  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != lut2d_pkg::S_IDLE) || out_v_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_v_r;
  assign out_word  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= 5'd16;
      rows_r <= 5'd16;
    end else if (cfg_valid) begin
      case (cfg_index[0])
        lut2d_pkg::CFG_COLS: cols_r <= cfg_data[4:0];
        lut2d_pkg::CFG_ROWS: rows_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // writes from input words
  always_ff @(posedge clk) begin
    if (accept) begin
      case (in_word.action)
        lut2d_pkg::ACT_CELL:
          cell_mem[{in_word.row_index, in_word.col_index}] <= in_word.data_value;
        lut2d_pkg::ACT_XREF: xref_mem[in_word.col_index] <= in_word.data_value;
        lut2d_pkg::ACT_YREF: yref_mem[in_word.row_index] <= in_word.data_value;
        default: ;
      endcase
    end
  end

  // interpolation arithmetic: sub-steps of the lerp
  logic signed [32:0] dy, dx, dd;
  logic [32:0] mag;
  assign dy  = 33'(c1_r) - 33'(c0_r);
  assign dx  = (pass2_r ? 33'(qx_r) : 33'(qy_r)) - 33'(x0_r);
  assign dd  = 33'(x1_r) - 33'(x0_r);
  assign mag = dy[32] ? 33'(-dy) : 33'(dy);

  logic [33:0] trial;
  assign trial = {rem_r, num_r[63]} - {1'b0, den_r};

  logic signed [33:0] lsum;
  logic signed [31:0] lres;
  always_comb begin
    lsum = neg_r ? 34'(y0_r) - 34'(quo_r[32:0]) : 34'(y0_r) + 34'(quo_r[32:0]);
    if (quo_r[63:33] != '0) lsum = neg_r ? -34'sd8589934592 : 34'sd8589934591;
    if (lsum > 34'sh07FFFFFFF)       lres = 32'sh7FFFFFFF;
    else if (lsum < -34'sh080000000) lres = 32'sh80000000;
    else                             lres = lsum[31:0];
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r;
    lo_nxt = lo_r;
    case (state_r)
      lut2d_pkg::S_IDLE:
        if (accept && in_word.action == lut2d_pkg::ACT_QUERY) begin
          state_nxt = lut2d_pkg::S_YRD;
          i_nxt = '0;
        end
      lut2d_pkg::S_YRD:
        state_nxt = (i_r + 5'd1 < rows_u) ? lut2d_pkg::S_YCMP : lut2d_pkg::S_OUT;
      lut2d_pkg::S_YCMP:
        if (a_r <= qy_r && b_r > qy_r) begin
          lo_nxt = i_r[3:0];
          i_nxt = '0;
          state_nxt = lut2d_pkg::S_RROW;
        end else begin
          i_nxt = i_r + 5'd1;
          state_nxt = lut2d_pkg::S_YRD;
        end
      lut2d_pkg::S_RROW: state_nxt = lut2d_pkg::S_LSET;
      lut2d_pkg::S_LSET: state_nxt = lut2d_pkg::S_MUL;
      lut2d_pkg::S_MUL:  state_nxt = lut2d_pkg::S_DIV;
      lut2d_pkg::S_DIV:  if (cnt_r == 7'd63) state_nxt = lut2d_pkg::S_LEND;
      lut2d_pkg::S_LEND:
        if (pass2_r) state_nxt = lut2d_pkg::S_OUT;
        else if (i_r + 5'd1 < cols_u) begin
          i_nxt = i_r + 5'd1;
          state_nxt = lut2d_pkg::S_RROW;
        end else begin
          i_nxt = '0;
          state_nxt = lut2d_pkg::S_XRD;
        end
      lut2d_pkg::S_XRD:
        state_nxt = (i_r + 5'd1 < cols_u) ? lut2d_pkg::S_XCMP : lut2d_pkg::S_OUT;
      lut2d_pkg::S_XCMP:
        if (a_r <= qx_r && b_r > qx_r) begin
          lo_nxt = i_r[3:0];
          state_nxt = lut2d_pkg::S_XSET;
        end else begin
          i_nxt = i_r + 5'd1;
          state_nxt = lut2d_pkg::S_XRD;
        end
      lut2d_pkg::S_XSET: state_nxt = lut2d_pkg::S_LSET;
      lut2d_pkg::S_OUT:  state_nxt = lut2d_pkg::S_IDLE;
      default: state_nxt = lut2d_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lut2d_pkg::S_IDLE;
      out_v_r <= 1'b0;
      pass2_r <= 1'b0;
      i_r <= '0;
      lo_r <= '0;
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt;
      lo_r <= lo_nxt;
      if (out_v_r && !out_stall) out_v_r <= 1'b0;
      case (state_r)
        lut2d_pkg::S_IDLE:
          // only on acceptance, so a waiting result stays put
          if (accept) begin
            qx_r <= in_word.query_x;
            qy_r <= in_word.query_y;
            pass2_r <= 1'b0;
            res_r.standardized_value <= in_word.query_x;
            res_r.status <= lut2d_pkg::ST_YOUT;
          end
        lut2d_pkg::S_YRD: begin
          a_r <= yref_mem[i_r[3:0]];
          b_r <= yref_mem[4'(i_r + 5'd1)];
        end
        lut2d_pkg::S_RROW: begin
          x0_r <= yref_mem[lo_r];
          x1_r <= yref_mem[4'(lo_r + 4'd1)];
          c0_r <= cell_mem[{lo_r, i_r[3:0]}];
          c1_r <= cell_mem[{4'(lo_r + 4'd1), i_r[3:0]}];
        end
        lut2d_pkg::S_LSET: begin
          y0_r <= c0_r;
          neg_r <= dy[32];
          den_r <= dd;
        end
        lut2d_pkg::S_MUL: begin
          num_r <= 64'(mag[31:0] * 32'(unsigned'(dx[31:0]))) |
                   (mag[32] ? 64'(dx[31:0]) << 32 : 64'd0);
          rem_r <= '0;
          quo_r <= '0;
          cnt_r <= '0;
        end
        lut2d_pkg::S_DIV: begin
          cnt_r <= cnt_r + 7'd1;
          num_r <= {num_r[62:0], 1'b0};
          if (!trial[33]) begin
            rem_r <= trial[32:0];
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= {rem_r[31:0], num_r[63]};
            quo_r <= {quo_r[62:0], 1'b0};
          end
        end
        lut2d_pkg::S_LEND:
          if (pass2_r) begin
            res_r.standardized_value <= lres;
            res_r.status <= lut2d_pkg::ST_OK;
          end else begin
            irow_mem[i_r[3:0]] <= lres;
            res_r.status <= lut2d_pkg::ST_XOUT;
          end
        lut2d_pkg::S_XRD: begin
          a_r <= irow_mem[i_r[3:0]];
          b_r <= irow_mem[4'(i_r + 5'd1)];
        end
        lut2d_pkg::S_XSET: begin
          pass2_r <= 1'b1;
          x0_r <= a_r;
          x1_r <= b_r;
          c0_r <= xref_mem[lo_r];
          c1_r <= xref_mem[4'(lo_r + 4'd1)];
        end
        lut2d_pkg::S_OUT: out_v_r <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
